// ----- rtl/tccw_pkg.sv -----
`default_nettype none

package tccw_pkg;

    // Field widths of the item channels
    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int ROWF_W = 5;
    localparam int COLF_W = 7;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // Default geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Character and color constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd240;
    localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, SPACE_CODE};

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_ERASE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/tccw_in_if.sv -----
`default_nettype none

interface tccw_in_if;
    import tccw_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROWF_W-1:0] read_row;
    logic [COLF_W-1:0] read_col;

    modport source (output valid, output mode, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input mode, input char_code, input read_row,
                    input read_col, output ready);
endinterface

`default_nettype wire

// ----- rtl/tccw_out_if.sv -----
`default_nettype none

interface tccw_out_if;
    import tccw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROWF_W-1:0] cursor_row;
    logic [COLF_W-1:0] cursor_col;
    logic [CELL_W-1:0] cell_word;

    modport source (output valid, output cursor_row, output cursor_col,
                    output cell_word, input ready);
    modport sink   (input valid, input cursor_row, input cursor_col,
                    input cell_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/text_console_cell_writer.sv -----
`default_nettype none
// Put, newline, erase, no-op and out-of-range read load the result register on accept,
//   or via the finish state while the output is full; an in-range read passes the
//   registered RAM read, the read state and the finish state. A put or newline that
//   scrolls rotates rows through a top-row pointer, and the single RAM write port blanks
//   the new bottom row one cell a cycle. Reset: synchronous; the RAM is swept to blanks
//   in the reset color; no item is accepted meanwhile (color register writes are taken).

module text_console_cell_writer #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tccw_pkg::ATTR_W-1:0] i_cfg_wdata,
    tccw_in_if.sink                          i_item,
    tccw_out_if.source                       o_result
);
    import tccw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [ATTR_W-1:0]  r_attr;
    logic [ADDR_W-1:0]  r_clr;
    logic [COL_W-1:0]   r_scol;
    logic [ROW_W-1:0]   r_srow;
    logic               r_is_read;
    logic               r_ovalid;
    logic [ROWF_W-1:0]  r_orow;
    logic [COLF_W-1:0]  r_ocol;
    logic [CELL_W-1:0]  r_oword;

    logic               accept;
    logic               out_free;
    logic               op_write;
    logic               op_read;
    logic               op_scroll;
    logic [CELL_W-1:0]  op_wdata;
    logic [ROW_W-1:0]   op_lrow;
    logic [COL_W-1:0]   op_col;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic               wrap;
    logic [31:0]        rd_row_ext;
    logic [31:0]        rd_col_ext;
    logic [ROW_W:0]     phys_sum;
    logic [ROW_W-1:0]   phys_row;
    logic [ROW_W-1:0]   mem_row;
    logic [COL_W-1:0]   mem_col;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [CELL_W-1:0]  mem_rdata;
    logic               load;
    logic [CELL_W-1:0]  load_word;
    logic [31:0]        cur_row_ext;
    logic [31:0]        cur_col_ext;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_ovalid || o_result.ready;
    assign i_item.ready = (r_state == ST_IDLE);

    assign rd_row_ext = 32'(i_item.read_row);
    assign rd_col_ext = 32'(i_item.read_col);

    // Decode the item and work out the cursor after it
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_top     = r_top;
        op_write  = 1'b0;
        op_read   = 1'b0;
        op_scroll = 1'b0;
        op_wdata  = {r_attr, SPACE_CODE};
        op_lrow   = r_row;
        op_col    = r_col;
        col_inc   = {1'b0, r_col} + (COL_W+1)'(1);
        row_inc   = {1'b0, r_row} + (ROW_W+1)'(1);
        wrap      = 1'b0;
        if (accept) begin
            unique case (t_mode'(i_item.mode))
                MODE_PUT: begin
                    if (i_item.char_code == NEWLINE_CODE) begin
                        wrap = 1'b1;
                    end else begin
                        op_write = 1'b1;
                        op_wdata = {r_attr, i_item.char_code};
                        wrap     = (col_inc >= (COL_W+1)'(COLUMNS));
                        n_col    = col_inc[COL_W-1:0];
                    end
                    if (wrap) begin
                        n_col = '0;
                        if (row_inc >= (ROW_W+1)'(ROWS)) begin
                            op_scroll = 1'b1;
                            n_top = (r_top == ROW_W'(ROWS - 1)) ? '0
                                                                : r_top + ROW_W'(1);
                        end else begin
                            n_row = row_inc[ROW_W-1:0];
                        end
                    end
                end
                MODE_ERASE: begin
                    if (r_col > COL_W'(1)) begin
                        op_write = 1'b1;
                        n_col    = r_col - COL_W'(1);
                        op_col   = r_col - COL_W'(1);
                    end
                end
                MODE_READ: begin
                    op_lrow = rd_row_ext[ROW_W-1:0];
                    op_col  = rd_col_ext[COL_W-1:0];
                    op_read = (rd_row_ext < 32'(ROWS)) && (rd_col_ext < 32'(COLUMNS));
                end
                MODE_NOP: begin
                end
            endcase
        end
    end

    // Map the logical row through the top-row pointer
    always_comb begin
        phys_sum = {1'b0, op_lrow} + {1'b0, r_top};
        if (phys_sum >= (ROW_W+1)'(ROWS)) begin
            phys_sum = phys_sum - (ROW_W+1)'(ROWS);
        end
        phys_row = phys_sum[ROW_W-1:0];
    end

    // Drive the RAM port
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_row   = phys_row;
        mem_col   = op_col;
        mem_wdata = op_wdata;
        mem_addr  = ADDR_W'(mem_row) * ADDR_W'(COLUMNS) + ADDR_W'(mem_col);
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = RESET_BLANK;
                mem_addr  = r_clr;
            end
            ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_row   = r_srow;
                mem_col   = r_scol;
                mem_wdata = {r_attr, SPACE_CODE};
                mem_addr  = ADDR_W'(mem_row) * ADDR_W'(COLUMNS) + ADDR_W'(mem_col);
            end
            ST_IDLE: begin
                mem_we = op_write;
                mem_re = op_read;
            end
            default: begin
            end
        endcase
    end

    tccw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(CELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (op_scroll)      n_state = ST_SCROLL;
                    else if (op_read)   n_state = ST_READ;
                    else if (!out_free) n_state = ST_FINISH;
                end
            end
            ST_READ: begin
                n_state = ST_FINISH;
            end
            ST_SCROLL: begin
                if (r_scol == COL_W'(COLUMNS - 1)) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
        endcase
    end

    // Result load
    always_comb begin
        load      = 1'b0;
        load_word = '0;
        unique case (r_state) inside
            ST_IDLE: begin
                load = accept && !op_scroll && !op_read && out_free;
            end
            ST_FINISH: begin
                load      = out_free;
                load_word = r_is_read ? mem_rdata : '0;
            end
            ST_CLEAR, ST_READ, ST_SCROLL: begin
            end
        endcase
    end

    assign cur_row_ext = 32'(n_row);
    assign cur_col_ext = 32'(n_col);

    // Control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_row     <= '0;
            r_col     <= '0;
            r_top     <= '0;
            r_attr    <= RESET_ATTR;
            r_clr     <= '0;
            r_scol    <= '0;
            r_is_read <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_top   <= n_top;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (r_state == ST_SCROLL) begin
                r_scol <= r_scol + COL_W'(1);
            end else begin
                r_scol <= '0;
            end
            if (accept) begin
                r_is_read <= op_read;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_srow <= r_top;
        end
        if (load) begin
            r_orow  <= cur_row_ext[ROWF_W-1:0];
            r_ocol  <= cur_col_ext[COLF_W-1:0];
            r_oword <= load_word;
        end
    end

    assign o_result.valid      = r_ovalid;
    assign o_result.cursor_row = r_orow;
    assign o_result.cursor_col = r_ocol;
    assign o_result.cell_word  = r_oword;

    // Cursor and top-row pointer stay inside the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS) && (32'(r_top) < ROWS))
        else $error("cursor or top-row pointer out of range");

    // A scroll only happens with the cursor on the bottom row at column zero
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> ((32'(r_row) == ROWS - 1) && (r_col == '0)))
        else $error("scroll with cursor off the bottom row");

    // A scroll ends only in the finish state
    a_scroll_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |=> (r_state == ST_SCROLL || r_state == ST_FINISH))
        else $error("scroll left without finishing");

    // In idle the RAM is touched only for an accepted item
    a_idle_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (mem_we || mem_re)) |-> accept)
        else $error("RAM access in idle without an item");

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- rtl/tccw_cell_ram.sv -----
`default_nettype none

module tccw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic                       i_re,
    input  wire logic [ADDR_W-1:0]          i_addr,
    input  wire logic [tccw_pkg::CELL_W-1:0] i_wdata,
    output logic      [tccw_pkg::CELL_W-1:0] o_rdata
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    // Single port: write or registered read at one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
